FILE: src/pwg_pkg.sv
// shared types, constants and functions for the periodic waveform generator
// no dependencies; imported by every module of the block
package pwg_pkg;

	// phase and table geometry
	localparam int PHASE_BITS      = 24;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);
	localparam int SINE_IDX_BITS   = SINE_TABLE_BITS - 1;

	// fraction multiplier, two multiplier bits per cycle
	localparam int FRAC_BITS     = 24;
	localparam int FRAC_DIGITS   = FRAC_BITS / 2;
	localparam int FRAC_CNT_BITS = $clog2(FRAC_DIGITS);

	// waveform held as w + 1.0, unsigned, 0..65536
	localparam int WAVE_BITS    = 17;
	localparam int AMP_BITS     = 32;
	localparam int PROD_BITS    = AMP_BITS + 2;
	localparam int AMP_CNT_BITS = $clog2(WAVE_BITS);

	localparam logic [WAVE_BITS-1:0] WAVE_MID  = 17'h08000;
	localparam logic [WAVE_BITS-1:0] WAVE_FULL = 17'h10000;
	localparam logic [WAVE_BITS-1:0] WAVE_ZERO = 17'h00000;

	// 32-bit phase landmarks
	localparam logic [31:0] P_QUARTER = 32'h4000_0000;
	localparam logic [31:0] P_HALF    = 32'h8000_0000;
	localparam logic [31:0] P_3QUART  = 32'hC000_0000;

	localparam logic [23:0] DUTY_RESET  = 24'h80_0000;
	localparam logic [23:0] OFFSET_RESET = 24'h00_0000;

	localparam int REG_INDEX_BITS = 3;

	typedef enum logic [2:0] {
		SHAPE_SINE,
		SHAPE_TRIANGLE,
		SHAPE_SQUARE,
		SHAPE_SAWTOOTH,
		SHAPE_INV_SAWTOOTH,
		SHAPE_PWM
	} wave_shape_t;

	typedef enum logic [REG_INDEX_BITS-1:0] {
		REG_WAVE_SHAPE,
		REG_BASE_LEVEL,
		REG_CYCLES_PER_MS,
		REG_PHASE_OFFSET,
		REG_AMPLITUDE,
		REG_DUTY_FRACTION,
		REG_DELTA_MODE
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PMUL,
		ST_SHAPE,
		ST_LOAD,
		ST_AMUL
	} pwg_state_t;

	// shape selection handed to the shaper
	typedef struct packed {
		logic [2:0]  shape;
		logic [23:0] duty;
	} shape_cfg_t;

	// polynomial coefficients of the quarter sine, Q2.30
	localparam longint SIN_A1 = 64'sd1686629715;
	localparam longint SIN_A3 = 64'sd693598666;
	localparam longint SIN_A5 = 64'sd85569306;
	localparam longint SIN_A7 = 64'sd5026995;
	localparam longint SIN_A9 = 64'sd172272;

	typedef logic [WAVE_BITS-1:0] sine_lut_t [SINE_QUARTER+1];

	// sin(pi/2 * i/N) in Q1.15, evaluated at elaboration only
	function automatic logic [WAVE_BITS-1:0] quarter_sine(int i);
		longint x;
		longint x2;
		longint t;
		longint v;
		x  = longint'(i) <<< (30 - (SINE_TABLE_BITS - 2));
		x2 = (x * x) >>> 30;
		t  = SIN_A9;
		t  = SIN_A7 - ((x2 * t) >>> 30);
		t  = SIN_A5 - ((x2 * t) >>> 30);
		t  = SIN_A3 - ((x2 * t) >>> 30);
		t  = SIN_A1 - ((x2 * t) >>> 30);
		v  = (((x * t) >>> 30) + 64'sd16384) >>> 15;
		if (v > 64'sd32768) begin
			v = 64'sd32768;
		end
		return v[WAVE_BITS-1:0];
	endfunction

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		for (int k = 0; k <= SINE_QUARTER; k++) begin
			lut[k] = quarter_sine(k);
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

	// Q.24 fraction to a phase of PHASE_BITS bits, truncating
	function automatic logic [PHASE_BITS-1:0] q24_to_phase(logic [23:0] v);
		logic [PHASE_BITS+23:0] w;
		w = {v, {PHASE_BITS{1'b0}}};
		return w[PHASE_BITS+23:24];
	endfunction

	// phase widened to a 32-bit fraction
	function automatic logic [31:0] phase_to_p32(logic [PHASE_BITS-1:0] ph);
		return 32'(ph) << (32 - PHASE_BITS);
	endfunction

endpackage

FILE: src/periodic_waveform_generator_unit.sv
// Periodic waveform generator (LFO). Each time item yields one result item,
// passing in order through the two-bit-per-cycle multiplier that forms the
// phase step, the phase update, the waveform table and shaper, the bit-serial
// amplitude multiplier and the offset add and saturation. One item is in
// work at a time; time_stall stays high from acceptance until the result is
// written to the output register, which may still hold the previous result
// while the next item is worked on. Registers are written through the cfg
// port (always ready); the user must write them only while the block is
// idle, which the block itself does not enforce. Writing phase_offset also
// reloads the phase accumulator. Depends on pwg_pkg and its submodules.
module periodic_waveform_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwg_pkg::REG_INDEX_BITS-1:0]  cfg_index,
	input  logic [31:0]                         cfg_data,
	// time items
	input  logic                                time_valid,
	output logic                                time_stall,
	input  logic [31:0]                         time_ms,
	// result items
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [31:0]                  wave_value,
	output logic                                active
);
	import pwg_pkg::*;

	pwg_state_t state_q;
	pwg_state_t state_next;

	logic [2:0]             shape_q;
	logic signed [31:0]     base_q;
	logic [31:0]            freq_q;
	logic [23:0]            offset_q;
	logic signed [31:0]     amp_q;
	logic [23:0]            duty_q;
	logic                   delta_q;
	logic [PHASE_BITS-1:0]  acc_q;

	logic                   cfg_we;
	logic                   in_accept;
	logic                   fmul_start;
	logic                   fmul_busy;
	logic [FRAC_BITS-1:0]   frac;
	logic                   phase_en;
	logic [PHASE_BITS-1:0]  phase_next;
	logic [31:0]            phase_s1;
	shape_cfg_t             shape_cfg;
	logic [WAVE_BITS-1:0]   wave_s2;
	logic                   amul_start;
	logic                   amul_busy;
	logic signed [PROD_BITS-1:0] scaled;
	logic signed [PROD_BITS:0]   sum;
	logic signed [31:0]     sat;
	logic                   out_load;
	logic                   result_valid_q;
	logic signed [31:0]     wave_value_q;
	logic                   active_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign in_accept = time_valid & ~time_stall;

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_next = ST_PMUL;
				end
			end
			ST_PMUL: begin
				if (!fmul_busy) begin
					state_next = ST_SHAPE;
				end
			end
			ST_SHAPE: begin
				state_next = ST_LOAD;
			end
			ST_LOAD: begin
				state_next = ST_AMUL;
			end
			ST_AMUL: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		time_stall = (state_q != ST_IDLE);
		fmul_start = (state_q == ST_IDLE) && time_valid;
		phase_en   = (state_q == ST_PMUL) && !fmul_busy;
		amul_start = (state_q == ST_LOAD);
		out_load   = (state_q == ST_AMUL) && !amul_busy &&
			(!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// configuration registers and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= SHAPE_SINE;
			base_q   <= '0;
			freq_q   <= '0;
			offset_q <= OFFSET_RESET;
			amp_q    <= '0;
			duty_q   <= DUTY_RESET;
			delta_q  <= 1'b1;
			acc_q    <= q24_to_phase(OFFSET_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVE_SHAPE:    shape_q <= cfg_data[2:0];
				REG_BASE_LEVEL:    base_q  <= cfg_data;
				REG_CYCLES_PER_MS: freq_q  <= cfg_data;
				REG_PHASE_OFFSET: begin
					offset_q <= cfg_data[23:0];
					acc_q    <= q24_to_phase(cfg_data[23:0]);
				end
				REG_AMPLITUDE:     amp_q   <= cfg_data;
				REG_DUTY_FRACTION: duty_q  <= cfg_data[23:0];
				REG_DELTA_MODE:    delta_q <= cfg_data[0];
				default: begin
				end
			endcase
		end else if (phase_en && delta_q) begin
			acc_q <= phase_next;
		end
	end

	// fraction of time times frequency
	pwg_frac_mul u_frac_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fmul_start),
		.mplier (time_ms[FRAC_BITS-1:0]),
		.mcand  (freq_q[FRAC_BITS-1:0]),
		.busy   (fmul_busy),
		.frac   (frac)
	);

	// phase update, accumulated or absolute
	always_comb begin
		if (delta_q) begin
			phase_next = acc_q + q24_to_phase(frac);
		end else begin
			phase_next = q24_to_phase(frac + offset_q);
		end
	end

	always_ff @(posedge clk) begin
		if (phase_en) begin
			phase_s1 <= phase_to_p32(phase_next);
		end
	end

	assign shape_cfg.shape = shape_q;
	assign shape_cfg.duty  = duty_q;

	pwg_shaper u_shaper (
		.clk   (clk),
		.cfg   (shape_cfg),
		.phase (phase_s1),
		.wave  (wave_s2)
	);

	pwg_amp_mul u_amp_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (amul_start),
		.mplier  (wave_s2),
		.mcand   (amp_q),
		.busy    (amul_busy),
		.product (scaled)
	);

	// offset add and saturation to 32 bits
	always_comb begin
		sum = {{(PROD_BITS-31){base_q[31]}}, base_q} + {scaled[PROD_BITS-1], scaled};
		if (sum[PROD_BITS:31] == '0 || sum[PROD_BITS:31] == '1) begin
			sat = sum[31:0];
		end else if (sum[PROD_BITS]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7FFF_FFFF;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			wave_value_q <= sat;
			active_q     <= (base_q != '0) || (offset_q != '0) ||
				(freq_q != '0) || (amp_q != '0);
		end
	end

	assign result_valid = result_valid_q;
	assign wave_value   = wave_value_q;
	assign active       = active_q;

`ifndef SYNTHESIS
	a_fmul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fmul_busy |-> state_q == ST_PMUL)
		else $error("fraction multiplier busy outside its state");
	a_amul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		amul_busy |-> state_q == ST_AMUL)
		else $error("amplitude multiplier busy outside its state");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_AMUL)
		else $error("result raised without a finished item");
	a_wave_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> wave_s2 <= WAVE_FULL)
		else $error("waveform beyond full scale");
`endif

endmodule

FILE: src/pwg_frac_mul.sv
// serial multiplier that keeps the fraction bits of time times frequency
// two multiplier bits per cycle; depends on pwg_pkg
module pwg_frac_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pwg_pkg::FRAC_BITS-1:0] mplier,
	input  logic [pwg_pkg::FRAC_BITS-1:0] mcand,
	output logic                          busy,
	output logic [pwg_pkg::FRAC_BITS-1:0] frac
);
	import pwg_pkg::*;

	logic                     busy_q;
	logic [FRAC_CNT_BITS-1:0] cnt_q;
	logic [FRAC_BITS-1:0]     acc_q;
	logic [FRAC_BITS-1:0]     mpl_q;
	logic [FRAC_BITS-1:0]     mc_q;
	logic [FRAC_BITS-1:0]     acc_next;

	// one radix-4 digit: add 0, 1, 2 or 3 times the multiplicand, mod 2^24
	always_comb begin
		acc_next = acc_q
			+ (mpl_q[0] ? mc_q : '0)
			+ (mpl_q[1] ? {mc_q[FRAC_BITS-2:0], 1'b0} : '0);
	end

	// digit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= FRAC_CNT_BITS'(FRAC_DIGITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// shift registers and partial sum
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mpl_q <= mplier;
			mc_q  <= mcand;
		end else if (busy_q) begin
			acc_q <= acc_next;
			mpl_q <= {2'b00, mpl_q[FRAC_BITS-1:2]};
			mc_q  <= {mc_q[FRAC_BITS-3:0], 2'b00};
		end
	end

	assign busy = busy_q;
	assign frac = acc_q;

endmodule

FILE: src/pwg_shaper.sv
// maps a 32-bit phase to the selected waveform, offset by one (0..65536)
// registered output; quarter sine table from pwg_pkg
module pwg_shaper (
	input  logic                          clk,
	input  pwg_pkg::shape_cfg_t           cfg,
	input  logic [31:0]                   phase,
	output logic [pwg_pkg::WAVE_BITS-1:0] wave
);
	import pwg_pkg::*;

	logic [SINE_TABLE_BITS-1:0] top;
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-3:0] qidx;
	logic [SINE_IDX_BITS-1:0]   lidx;
	logic [WAVE_BITS-1:0]       sine_mag;
	logic [WAVE_BITS-1:0]       tri_dec;
	logic [WAVE_BITS-1:0]       wave_next;
	logic [WAVE_BITS-1:0]       wave_s2;

	// quarter-wave table address and mirrored lookup
	always_comb begin
		top      = phase[31 -: SINE_TABLE_BITS];
		quad     = top[SINE_TABLE_BITS-1 -: 2];
		qidx     = top[SINE_TABLE_BITS-3:0];
		lidx     = quad[0] ? SINE_IDX_BITS'(SINE_QUARTER) - {1'b0, qidx} : {1'b0, qidx};
		sine_mag = SINE_LUT[lidx];
		tri_dec  = phase[31:15] - P_QUARTER[31:15];
	end

	// shape select
	always_comb begin
		unique case (cfg.shape)
			SHAPE_SINE: begin
				wave_next = quad[1] ? WAVE_MID - sine_mag : WAVE_MID + sine_mag;
			end
			SHAPE_TRIANGLE: begin
				if (phase < P_QUARTER) begin
					wave_next = WAVE_MID + {2'b00, phase[29:15]};
				end else if (phase < P_3QUART) begin
					wave_next = WAVE_FULL - tri_dec;
				end else begin
					wave_next = {2'b00, phase[29:15]};
				end
			end
			SHAPE_SQUARE: begin
				wave_next = (phase <= P_HALF) ? WAVE_FULL : WAVE_ZERO;
			end
			SHAPE_SAWTOOTH: begin
				wave_next = {1'b0, phase[31:16]};
			end
			SHAPE_INV_SAWTOOTH: begin
				wave_next = WAVE_FULL - {1'b0, phase[31:16]};
			end
			SHAPE_PWM: begin
				wave_next = (phase <= {cfg.duty, 8'h00}) ? WAVE_FULL : WAVE_ZERO;
			end
			default: begin
				wave_next = WAVE_MID;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		wave_s2 <= wave_next;
	end

	assign wave = wave_s2;

endmodule

FILE: src/pwg_amp_mul.sv
// bit-serial signed multiplier: amplitude times offset waveform
// returns the product floored by 2^16; depends on pwg_pkg
module pwg_amp_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [pwg_pkg::WAVE_BITS-1:0]        mplier,
	input  logic signed [pwg_pkg::AMP_BITS-1:0]  mcand,
	output logic                                 busy,
	output logic signed [pwg_pkg::PROD_BITS-1:0] product
);
	import pwg_pkg::*;

	logic                       busy_q;
	logic [AMP_CNT_BITS-1:0]    cnt_q;
	logic signed [AMP_BITS:0]   hi_q;
	logic [WAVE_BITS-1:0]       lo_q;
	logic signed [AMP_BITS-1:0] mc_q;
	logic signed [AMP_BITS:0]   addend;
	logic signed [AMP_BITS:0]   sum;

	// add the multiplicand under the current multiplier bit
	always_comb begin
		addend = lo_q[0] ? {mc_q[AMP_BITS-1], mc_q} : '0;
		sum    = hi_q + addend;
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= AMP_CNT_BITS'(WAVE_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// partial product shifts right, low bits replace the multiplier
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= mplier;
			mc_q <= mcand;
		end else if (busy_q) begin
			hi_q <= {sum[AMP_BITS], sum[AMP_BITS:1]};
			lo_q <= {sum[0], lo_q[WAVE_BITS-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = {hi_q, lo_q[WAVE_BITS-1]};

endmodule
